// ----- src/acr_pkg.sv -----
// Shared types, codes and constants of the acknowledgement reply checker.
`timescale 1ns / 1ps

package acr_pkg;

	localparam int LINE_LIMIT_DEF  = 128;
	localparam int REPLY_BYTES_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int MIN_REPLY       = 9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	typedef enum logic [1:0] {
		OUT_IGNORED = 2'd0,
		OUT_ACK     = 2'd1,
		OUT_NACK    = 2'd2
	} outcome_t;

	typedef enum logic [0:0] {
		REG_ACK  = 1'b0,
		REG_NACK = 1'b1
	} cfg_reg_t;

	// Line parser position: five prefix characters, then the field scan.
	typedef enum logic [2:0] {
		PS_P0     = 3'd0,
		PS_P1     = 3'd1,
		PS_P2     = 3'd2,
		PS_P3     = 3'd3,
		PS_P4     = 3'd4,
		PS_FIELDS = 3'd5,
		PS_DONE   = 3'd6,
		PS_DEAD   = 3'd7
	} ps_t;

	typedef struct packed {
		ps_t        ps;
		logic [1:0] fld;
		logic       tok;
		logic       held_v;
		logic [3:0] held_n;
	} fe_state_t;

	localparam fe_state_t FE_IDLE = '{
		ps: PS_P0, fld: 2'd0, tok: 1'b0, held_v: 1'b0, held_n: 4'h0
	};

	typedef struct packed {
		fe_state_t  st;
		logic       wr;
		logic [7:0] data;
	} parse_res_t;

	// What the front hands to the back: a decoded reply byte, a line end, or both.
	typedef struct packed {
		logic       wr;
		logic [7:0] data;
		logic       fin;
		logic       tok_ok;
	} acr_event_t;

endpackage

// ----- src/acr_byte_if.sv -----
// Byte input channel: valid/ready handshake carrying one received byte.
`timescale 1ns / 1ps

interface acr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/acr_result_if.sv -----
// Result channel: valid/ready handshake carrying one line verdict.
`timescale 1ns / 1ps

interface acr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;
	logic       seq_now;

	modport source (output valid, output outcome, output seq_now, input ready);
	modport sink (input valid, input outcome, input seq_now, output ready);
endinterface

// ----- src/acr_front.sv -----
// Front end: line framing, prefix match, field scan and hex decoding.
`timescale 1ns / 1ps

module acr_front
	import acr_pkg::*;
#(
	parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	acr_byte_if.sink   rx,
	input  logic       q_ready,
	output logic       ev_push,
	output acr_event_t ev
);

	localparam int LEN_W = $clog2(LINE_LIMIT);

	function automatic logic [7:0] prefix_char(ps_t p);
		logic [7:0] ch;
		unique case (p)
			PS_P0:   ch = 8'h2B; // '+'
			PS_P1:   ch = 8'h52; // 'R'
			PS_P2:   ch = 8'h43; // 'C'
			PS_P3:   ch = 8'h56; // 'V'
			PS_P4:   ch = 8'h3D; // '='
			default: ch = CHAR_NUL;
		endcase
		return ch;
	endfunction

	// Non-hex characters decode as zero.
	function automatic logic [3:0] nibble_of(logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		priority if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
		else t = 8'h00;
		return t[3:0];
	endfunction

	function automatic parse_res_t parse_char(fe_state_t s, logic [7:0] c);
		parse_res_t r;
		logic [1:0] fld_n;
		logic [3:0] v;
		r = '{st: s, wr: 1'b0, data: 8'h00};
		fld_n = s.fld;
		v = nibble_of(c);
		if (s.ps != PS_DONE && s.ps != PS_DEAD) begin
			priority if (c == CHAR_NUL) begin
				r.st.ps = (s.ps == PS_FIELDS && s.fld == 2'd3) ? PS_DONE : PS_DEAD;
			end else if (s.ps != PS_FIELDS) begin
				r.st.ps = (c == prefix_char(s.ps)) ? ps_t'(s.ps + 3'd1) : PS_DEAD;
			end else if (c == CHAR_COMMA) begin
				r.st.tok = 1'b0;
				if (s.fld == 2'd3) r.st.ps = PS_DONE;
			end else begin
				if (!s.tok) begin
					r.st.tok = 1'b1;
					fld_n = s.fld + 2'd1;
					r.st.fld = fld_n;
				end
				if (fld_n == 2'd3) begin
					if (!s.held_v) begin
						r.st.held_v = 1'b1;
						r.st.held_n = v;
					end else begin
						r.wr = 1'b1;
						r.data = {s.held_n, v};
						r.st.held_v = 1'b0;
						r.st.held_n = 4'h0;
					end
				end
			end
		end
		return r;
	endfunction

	fe_state_t      st_q, st_n;
	logic           pend_q, pend_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [LEN_W:0] len_inc;
	parse_res_t     r1, r2;
	logic           fin, accept, is_lf;

	assign rx.ready = q_ready;
	assign accept   = rx.valid && q_ready;
	assign is_lf    = (rx.rx_byte == CHAR_LF);
	assign len_inc  = {1'b0, len_q} + (LEN_W + 1)'(1);

	always_comb begin
		r1     = '{st: st_q, wr: 1'b0, data: 8'h00};
		fin    = 1'b0;
		pend_n = pend_q;
		// A held carriage return either merges into a newline or becomes text.
		if (pend_q) begin
			pend_n = 1'b0;
			if (is_lf) fin = 1'b1;
			else r1 = parse_char(st_q, CHAR_CR);
		end else if (is_lf) begin
			fin = 1'b1;
		end
		r2 = '{st: r1.st, wr: 1'b0, data: 8'h00};
		if (!fin) begin
			if (len_inc >= (LEN_W + 1)'(LINE_LIMIT - 1)) begin
				r2  = parse_char(r1.st, rx.rx_byte);
				fin = 1'b1;
			end else if (rx.rx_byte == CHAR_CR) begin
				pend_n = 1'b1;
			end else begin
				r2 = parse_char(r1.st, rx.rx_byte);
			end
		end

		// At most one of the two parse steps completes a byte.
		ev.wr     = r1.wr | r2.wr;
		ev.data   = r1.wr ? r1.data : r2.data;
		ev.fin    = fin;
		ev.tok_ok = (r2.st.ps == PS_DONE) || (r2.st.ps == PS_FIELDS && r2.st.fld == 2'd3);
		ev_push   = accept && (ev.wr || fin);

		if (fin) begin
			st_n   = FE_IDLE;
			pend_n = 1'b0;
			len_n  = '0;
		end else begin
			st_n  = r2.st;
			len_n = len_inc[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= FE_IDLE;
			pend_q <= 1'b0;
			len_q  <= '0;
		end else if (accept) begin
			st_q   <= st_n;
			pend_q <= pend_n;
			len_q  <= len_n;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, len_q} < (LEN_W + 1)'(LINE_LIMIT - 1))
		else $error("line length passed the limit");

endmodule

// ----- src/acr_queue.sv -----
// Short event queue between the front end and the checking back end.
`timescale 1ns / 1ps

module acr_queue
	import acr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  acr_event_t push_ev,
	output logic       not_full,
	input  logic       pop,
	output logic       head_valid,
	output acr_event_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	acr_event_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_full   = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop) rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

// ----- src/acr_back.sv -----
// Back end: CRC over the decoded reply, sequence check and verdict register.
`timescale 1ns / 1ps

module acr_back
	import acr_pkg::*;
#(
	parameter int REPLY_BYTES = REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  acr_event_t  head,
	output logic        pop,
	input  logic [31:0] ack_value,
	input  logic [31:0] nack_value,
	acr_result_if.source res
);

	localparam int BC_W = $clog2(REPLY_BYTES + 1);

	function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	logic [BC_W-1:0] bc_q, bc_n;
	logic [15:0]     crc_q, crc_n;
	logic [7:0]      last1_q, last1_n, last2_q, last2_n;
	logic [3:0]      nib_q, nib_n;
	logic [31:0]     msg_q, msg_n;
	logic            seq_q;
	logic            res_valid_q, seq_now_q;
	outcome_t        outcome_q, verdict;
	logic            ok;
	logic [1:0]      mi;

	assign pop         = head_valid && (!head.fin || !res_valid_q || res.ready);
	assign res.valid   = res_valid_q;
	assign res.outcome = outcome_q;
	assign res.seq_now = seq_now_q;
	assign mi          = 2'(bc_q - BC_W'(3));

	always_comb begin
		bc_n    = bc_q;
		crc_n   = crc_q;
		last1_n = last1_q;
		last2_n = last2_q;
		nib_n   = nib_q;
		msg_n   = msg_q;
		// Fold in the byte two places behind the newest; the last two are the check.
		if (head.wr && bc_q < BC_W'(REPLY_BYTES)) begin
			if (bc_q >= BC_W'(2)) crc_n = crc_fold(crc_q, last2_q);
			last2_n = last1_q;
			last1_n = head.data;
			if (bc_q == BC_W'(2)) nib_n = head.data[3:0];
			if (bc_q >= BC_W'(3) && bc_q <= BC_W'(6)) msg_n[{mi, 3'b000} +: 8] = head.data;
			bc_n = bc_q + BC_W'(1);
		end
		ok = head.tok_ok && (bc_n >= BC_W'(MIN_REPLY)) && ({last1_n, last2_n} == crc_n)
			&& (nib_n == {3'b000, seq_q});
		priority if (ok && msg_n == ack_value) verdict = OUT_ACK;
		else if (ok && msg_n == nack_value) verdict = OUT_NACK;
		else verdict = OUT_IGNORED;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last1_q <= last1_n;
			last2_q <= last2_n;
			nib_q   <= nib_n;
			msg_q   <= msg_n;
		end
		if (pop && head.fin) begin
			outcome_q <= verdict;
			seq_now_q <= seq_q ^ (verdict == OUT_ACK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= '0;
			crc_q       <= CRC_INIT;
			seq_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && head.fin) begin
				bc_q        <= '0;
				crc_q       <= CRC_INIT;
				seq_q       <= seq_q ^ (verdict == OUT_ACK);
				res_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					bc_q  <= bc_n;
					crc_q <= crc_n;
				end
				if (res.ready) res_valid_q <= 1'b0;
			end
		end
	end

	a_bc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BC_W'(REPLY_BYTES))
		else $error("reply byte count beyond the store");

	a_seq_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != $past(seq_q)) |-> (res_valid_q && outcome_q == OUT_ACK
			&& seq_now_q == seq_q))
		else $error("sequence bit moved without an acknowledged line");

endmodule

// ----- src/ack_reply_checker.sv -----
// Top level of the acknowledgement reply checker.
`timescale 1ns / 1ps

// Usage
//   rx  : received modem bytes, one per transaction (valid/ready).
//   res : one transaction per completed line: outcome (0 ignored, 1 acknowledged,
//         2 rejected) and seq_now, the sequence bit after that line.
//   cfg : write port for ack_value (index 0) and nack_value (index 1); write only
//         while no line end is still in flight.
// Timing
//   One byte is taken every cycle while the event queue has room. A line's verdict
//   reaches res through the event queue and the result register: the front parses
//   combinationally and writes the queue at the edge that accepts the last byte,
//   and the back pops it, behind any queued events, into the result register. The
//   CRC folds one reply byte per cycle as bytes pop, two bytes behind the decoder.
// Reset
//   arst_n clears the parser, the queue, the CRC, the sequence bit and the result
//   slot; ack_value returns to 1 and nack_value to 0. No clearing pass is needed.
// Back-pressure
//   When res stalls, one verdict waits in the result register while the queue
//   keeps taking events; rx.ready drops only once the queue is full.

module ack_reply_checker
	import acr_pkg::*;
#(
	parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
	parameter int REPLY_BYTES = REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	acr_byte_if.sink    rx,
	acr_result_if.source res,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	logic [31:0] ack_q, nack_q;
	acr_event_t  ev, head;
	logic        ev_push, q_ready, head_valid, pop;

	// Configuration registers: plain writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q  <= 32'd1;
			nack_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_ACK:  ack_q  <= cfg_data;
				REG_NACK: nack_q <= cfg_data;
				default:  ack_q  <= ack_q;
			endcase
		end
	end

	// Parse and decode; only bytes that produce a reply byte or end a line
	// leave an event.
	acr_front #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.q_ready (q_ready),
		.ev_push (ev_push),
		.ev      (ev)
	);

	// Decouple the parser from the verdict stage so either may stall alone.
	acr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (ev_push),
		.push_ev    (ev),
		.not_full   (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Fold the CRC, check sequence and message, hold the verdict.
	acr_back #(
		.REPLY_BYTES (REPLY_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ack_value  (ack_q),
		.nack_value (nack_q),
		.res        (res)
	);

endmodule

// ----- test/ack_reply_checker_tb.sv -----
// Self-checking testbench for the acknowledgement reply checker.
`timescale 1ns / 1ps

module ack_reply_checker_tb;
	import acr_pkg::*;

	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [39:0] RCV_PREFIX = "+RCV=";

	// Line shaping options for the reply generator
	localparam int ST_CRLF   = 1;
	localparam int ST_ODD    = 2;
	localparam int ST_ZERO   = 4;
	localparam int ST_TAIL   = 8;
	localparam int ST_BADPFX = 16;
	localparam int ST_BADHEX = 32;
	localparam int ST_CRMID  = 64;

	typedef struct packed {
		outcome_t outcome;
		logic     seq_now;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cfg_reg_t    cfg_idx;
	logic [31:0] cfg_data;

	acr_byte_if   rx ();
	acr_result_if res ();

	ack_reply_checker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// ------------------------------------------------------------------
	// Line checker model: its own copy of the parser state and registers.
	// ------------------------------------------------------------------
	logic [31:0] ack_reg   = 32'd1;
	logic [31:0] nack_reg  = 32'd0;
	int          line_len  = 0;
	ps_t         scan_ps   = PS_P0;
	int          tok_count = 0;
	bit          tok_open  = 1'b0;
	logic [4:0]  held_nib  = 5'd0;
	int          dec_count = 0;
	logic [7:0]  dec_bytes [REPLY_BYTES_DEF];
	logic [15:0] crc_acc   = CRC_INIT;
	bit          cr_held   = 1'b0;
	bit          exp_seq   = 1'b0;

	verdict_t    verdict_q [$];
	logic [7:0]  pend_bytes [$];

	// Bookkeeping
	int bytes_queued = 0;
	int bytes_taken  = 0;
	int phase_bytes  = 0;
	int cycle_cnt    = 0;
	int errors       = 0;
	int stall_cycles = 0;
	int n_ack        = 0;
	int n_nack       = 0;
	int n_ignored    = 0;
	int settings     = 1;
	int idle_pct     = IDLE_PCT;
	bit plan_seq     = 1'b0;
	bit hold_go      = 1'b0;
	logic hold_on    = 1'b0;
	logic rx_taken   = 1'b0;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		return x;
	endfunction

	function automatic logic [3:0] hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
		return 4'h0;
	endfunction

	function automatic void start_line();
		line_len  = 0;
		scan_ps   = PS_P0;
		tok_count = 0;
		tok_open  = 1'b0;
		held_nib  = 5'd0;
		dec_count = 0;
		crc_acc   = CRC_INIT;
		cr_held   = 1'b0;
	endfunction

	// Pair hex digits into reply bytes; the CRC trails the store by two bytes
	function automatic void take_digit(logic [7:0] c);
		logic [3:0] v;
		v = hex_value(c);
		if (!held_nib[4]) begin
			held_nib = {1'b1, v};
			return;
		end
		if (dec_count < REPLY_BYTES_DEF) begin
			dec_bytes[dec_count] = {held_nib[3:0], v};
			if (dec_count >= 2) crc_acc = crc_fold(crc_acc, dec_bytes[dec_count - 2]);
			dec_count++;
		end
		held_nib = 5'd0;
	endfunction

	function automatic void scan_char(logic [7:0] c);
		if (scan_ps == PS_DONE || scan_ps == PS_DEAD) return;
		if (c == CHAR_NUL) begin
			scan_ps = (scan_ps == PS_FIELDS && tok_count == 3) ? PS_DONE : PS_DEAD;
			return;
		end
		if (scan_ps != PS_FIELDS) begin
			if (c == RCV_PREFIX[39 - 8 * int'(scan_ps) -: 8]) scan_ps = ps_t'(scan_ps + 1);
			else scan_ps = PS_DEAD;
			return;
		end
		if (c == CHAR_COMMA) begin
			tok_open = 1'b0;
			if (tok_count == 3) scan_ps = PS_DONE;
			return;
		end
		if (!tok_open) begin
			tok_open = 1'b1;
			tok_count++;
		end
		if (tok_count == 3) take_digit(c);
	endfunction

	function automatic verdict_t close_line();
		verdict_t    v;
		logic [15:0] got;
		logic [31:0] msg;
		bit          have_tok;
		v.outcome = OUT_IGNORED;
		have_tok = (scan_ps == PS_DONE) || (scan_ps == PS_FIELDS && tok_count == 3);
		if (have_tok && dec_count >= MIN_REPLY) begin
			got = {dec_bytes[dec_count - 1], dec_bytes[dec_count - 2]};
			if (got == crc_acc && dec_bytes[2][3:0] == {3'b000, exp_seq}) begin
				msg = {dec_bytes[6], dec_bytes[5], dec_bytes[4], dec_bytes[3]};
				if (msg == ack_reg) begin
					exp_seq = ~exp_seq;
					v.outcome = OUT_ACK;
				end else if (msg == nack_reg) begin
					v.outcome = OUT_NACK;
				end
			end
		end
		v.seq_now = exp_seq;
		start_line();
		return v;
	endfunction

	// Advance the model by one received byte; return 1 when a line completes
	function automatic bit track_rx_byte(logic [7:0] c, output verdict_t v);
		if (cr_held) begin
			cr_held = 1'b0;
			if (c == CHAR_LF) begin
				v = close_line();
				return 1'b1;
			end
			scan_char(CHAR_CR);
		end else if (c == CHAR_LF) begin
			v = close_line();
			return 1'b1;
		end
		line_len++;
		if (line_len >= LINE_LIMIT_DEF - 1) begin
			scan_char(c);
			v = close_line();
			return 1'b1;
		end
		if (c == CHAR_CR) begin
			cr_held = 1'b1;
			return 1'b0;
		end
		scan_char(c);
		return 1'b0;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d (line %0d, cycle %0d)",
			field, got, want, n_ack + n_nack + n_ignored, cycle_cnt);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers: build byte streams into the pending queue.
	// ------------------------------------------------------------------
	task automatic push_char(logic [7:0] c);
		pend_bytes.push_back(c);
		bytes_queued++;
		phase_bytes++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endtask

	function automatic logic [7:0] any_but_lf();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CHAR_LF);
		return b;
	endfunction

	// A zero nibble may be sent as a non-hex character, which decodes to zero anyway
	function automatic logic [7:0] hex_digit(logic [3:0] v, bit allow_bad);
		string up = "0123456789ABCDEF";
		string lo = "0123456789abcdef";
		string bad = "gGxz.-_ +=";
		if (allow_bad && v == 4'h0 && $urandom_range(2) == 0)
			return bad[$urandom_range(bad.len() - 1)];
		return $urandom_range(1) ? up[v] : lo[v];
	endfunction

	task automatic push_token(bit with_cr);
		string pool = "0123456789-ABxyz";
		repeat ($urandom_range(1, 3)) push_char(pool[$urandom_range(pool.len() - 1)]);
		if (with_cr) begin
			push_char(CHAR_CR);
			push_char(pool[$urandom_range(pool.len() - 1)]);
		end
	endtask

	// One reply line: prefix, two filler fields, the hex reply and its ending
	task automatic queue_reply(int n_bytes, logic [31:0] msg, bit seq_right, bit crc_right,
			int style);
		logic [7:0]  r [32];
		logic [15:0] c;
		logic [3:0]  nib;
		int          k;
		int          bad_at;
		bit          bad_ok;
		for (int i = 0; i < n_bytes; i++) r[i] = 8'($urandom);
		nib = {3'b000, plan_seq};
		if (!seq_right) begin
			do nib = 4'($urandom_range(15)); while (nib == {3'b000, plan_seq});
		end
		if (n_bytes > 2) r[2] = {r[2][7:4], nib};
		if (n_bytes > 6) begin
			r[3] = msg[7:0];
			r[4] = msg[15:8];
			r[5] = msg[23:16];
			r[6] = msg[31:24];
		end
		// Bytes past the store are dropped, so the CRC sits in the last kept pair
		k = (n_bytes > REPLY_BYTES_DEF) ? REPLY_BYTES_DEF : n_bytes;
		if (k >= MIN_REPLY) begin
			c = CRC_INIT;
			for (int i = 0; i < k - 2; i++) c = crc_fold(c, r[i]);
			if (!crc_right) c = c ^ 16'(1 << $urandom_range(15));
			r[k - 2] = c[7:0];
			r[k - 1] = c[15:8];
		end
		bad_at = (style & ST_BADPFX) ? $urandom_range(4) : -1;
		for (int i = 0; i < 5; i++)
			push_char((i == bad_at) ? 8'("x") : RCV_PREFIX[39 - 8 * i -: 8]);
		if ($urandom_range(3) == 0) push_char(CHAR_COMMA);
		push_token((style & ST_CRMID) != 0);
		push_char(CHAR_COMMA);
		if ($urandom_range(3) == 0) push_char(CHAR_COMMA);
		push_token(1'b0);
		push_char(CHAR_COMMA);
		bad_ok = (style & ST_BADHEX) != 0;
		for (int i = 0; i < n_bytes; i++) begin
			push_char(hex_digit(r[i][7:4], bad_ok));
			push_char(hex_digit(r[i][3:0], bad_ok));
		end
		if (style & ST_ODD) push_char(hex_digit(4'($urandom), 1'b0));
		if (style & ST_TAIL) begin
			push_char(CHAR_COMMA);
			push_token(1'b0);
		end
		if (style & ST_ZERO) begin
			push_char(CHAR_NUL);
			repeat ($urandom_range(5)) push_char(any_but_lf());
		end
		if (style & ST_CRLF) push_char(CHAR_CR);
		push_char(CHAR_LF);
		// Track the sequence bit so later lines carry the nibble the block expects
		if (seq_right && crc_right && k >= MIN_REPLY && !(style & ST_BADPFX) && msg == ack_reg)
			plan_seq = ~plan_seq;
	endtask

	task automatic queue_random_line();
		int          pick;
		int          sz;
		int          style;
		logic [31:0] msg;
		pick = $urandom_range(99);
		sz = $urandom_range(99);
		if (sz < 80) sz = $urandom_range(9, 16);
		else if (sz < 88) sz = $urandom_range(17, 22);
		else if (sz < 95) sz = $urandom_range(3, 8);
		else sz = $urandom_range(0, 2);
		msg = $urandom_range(99);
		if (msg < 45) msg = ack_reg;
		else if (msg < 75) msg = nack_reg;
		else msg = 32'($urandom);
		style = 0;
		if ($urandom_range(1)) style |= ST_CRLF;
		if ($urandom_range(9) == 0) style |= ST_ODD;
		if ($urandom_range(9) == 0) style |= ST_ZERO;
		if ($urandom_range(4) == 0) style |= ST_TAIL;
		if ($urandom_range(2) == 0) style |= ST_BADHEX;
		if ($urandom_range(9) == 0) style |= ST_CRMID;
		if (pick < 70) begin
			queue_reply(sz, msg, $urandom_range(99) < 85, $urandom_range(99) < 85, style);
		end else if (pick < 78) begin
			repeat ($urandom_range(1, 40)) push_char(any_but_lf());
			push_char(CHAR_LF);
		end else if (pick < 81) begin
			// No newline at all: the length limit closes the line
			repeat (LINE_LIMIT_DEF - 1) push_char(any_but_lf());
		end else if (pick < 88) begin
			queue_reply(sz, msg, 1'b1, 1'b1, style | ST_BADPFX);
		end else if (pick < 94) begin
			push_text("+RCV=");
			push_token(1'b0);
			push_char(CHAR_COMMA);
			push_token(1'b0);
			if ($urandom_range(1)) push_char(CHAR_COMMA);
			push_char(CHAR_LF);
		end else if (pick < 97) begin
			push_char(CHAR_LF);
		end else begin
			push_char(CHAR_CR);
			push_char(CHAR_CR);
			push_text("+RCV=1,2,3");
			push_char(CHAR_CR);
			push_char(CHAR_LF);
		end
	endtask

	task automatic fill_random(int budget);
		phase_bytes = 0;
		while (phase_bytes < budget) queue_random_line();
	endtask

	// Wait until every byte is taken and every verdict has arrived, then let it settle
	task automatic wait_idle();
		do @(negedge clk); while (bytes_taken != bytes_queued || verdict_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		plan_seq = exp_seq;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACK) ack_reg = value;
		else nack_reg = value;
	endtask

	task automatic set_regs(logic [31:0] ack_word, logic [31:0] nack_word);
		write_reg(REG_ACK, ack_word);
		write_reg(REG_NACK, nack_word);
		settings++;
	endtask

	// ------------------------------------------------------------------
	// Byte driver: hold the offered byte until taken, advance at the falling edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : byte_driver
		if (!rx.valid || rx_taken) begin
			if (arst_n && pend_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
				rx.valid   <= 1'b1;
				rx.rx_byte <= pend_bytes.pop_front();
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Result sink: random back-pressure, plus the long hold when asked
	always @(negedge clk) begin : verdict_sink
		res.ready <= arst_n && !hold_on && ($urandom_range(99) >= idle_pct);
	end

	// Hold off the result side long enough for the event queue to fill and stall rx
	initial begin : result_hold
		wait (hold_go);
		@(negedge clk) hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: feed the model with each accepted byte, check each verdict.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		verdict_t fresh;
		verdict_t want;
		cycle_cnt++;
		if (!arst_n) begin
			rx_taken <= 1'b0;
		end else begin
			rx_taken <= rx.valid && rx.ready;
			if (rx.valid && !rx.ready) stall_cycles++;
			if (rx.valid && rx.ready) begin
				bytes_taken++;
				if (track_rx_byte(rx.rx_byte, fresh)) verdict_q.push_back(fresh);
			end
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected verdict, outcome", res.outcome, -1);
				end else begin
					want = verdict_q.pop_front();
					if (res.outcome !== want.outcome)
						report_mismatch("outcome", res.outcome, want.outcome);
					if (res.seq_now !== want.seq_now)
						report_mismatch("seq_now", res.seq_now, want.seq_now);
					case (want.outcome)
						OUT_ACK: n_ack++;
						OUT_NACK: n_nack++;
						default: n_ignored++;
					endcase
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Cycle limit of %0d reached with %0d verdicts outstanding",
			CYCLE_LIMIT, verdict_q.size());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		res.ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = REG_ACK;
		cfg_data   = 32'd0;
		arst_n     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		plan_seq = exp_seq;

		// Directed lines under reset register values (ack 1, nack 0)
		push_char(CHAR_LF);                                 // empty line
		queue_reply(9, 32'd1, 1'b1, 1'b1, ST_CRLF);         // shortest valid ack
		queue_reply(12, 32'd0, 1'b1, 1'b1, 0);              // rejected
		queue_reply(9, 32'd1, 1'b0, 1'b1, 0);               // wrong sequence nibble
		queue_reply(10, 32'd1, 1'b1, 1'b0, ST_CRLF);        // CRC mismatch
		queue_reply(8, 32'd1, 1'b1, 1'b1, 0);               // one byte short
		queue_reply(20, 32'd1, 1'b1, 1'b1, ST_ODD | ST_BADHEX); // long token, odd digit
		queue_reply(16, 32'd0, 1'b1, 1'b1, ST_ZERO | ST_CRMID); // zero byte, bare CR
		queue_reply(9, 32'hDEAD_BEEF, 1'b1, 1'b1, ST_TAIL); // matches neither register
		queue_reply(9, 32'd1, 1'b1, 1'b1, ST_BADPFX);       // prefix broken
		push_text("+RCV=5,");                               // zero before the third token
		push_char(CHAR_NUL);
		push_text("7,0123456789ABCDEF0011\n");
		repeat (LINE_LIMIT_DEF - 2) push_char("A");         // CR as the last character
		push_char(CHAR_CR);
		fill_random(170);
		wait_idle();

		set_regs(32'h7FFF_FFFF, 32'h8000_0000);
		fill_random(170);
		wait_idle();

		// Calm stretch: no idling on either side
		idle_pct = 0;
		set_regs(32'hFFFF_FFFF, 32'h0000_0000);
		fill_random(170);
		wait_idle();

		// Equal registers, and a long result hold while bytes keep coming
		ack_reg = 32'($urandom);
		set_regs(ack_reg, ack_reg);
		plan_seq = exp_seq;
		hold_go = 1'b1;
		repeat (60) push_char(CHAR_LF);
		fill_random(140);
		wait_idle();
		idle_pct = IDLE_PCT;

		set_regs(32'($urandom), 32'($urandom));
		fill_random(170);
		wait_idle();

		set_regs(32'h8000_0000, 32'h7FFF_FFFF);
		fill_random(170);
		wait_idle();

		$display("Checked %0d lines from %0d bytes over %0d register settings",
			n_ack + n_nack + n_ignored, bytes_taken, settings);
		$display("Verdicts: %0d acknowledged, %0d rejected, %0d ignored; rx stalled %0d cycles",
			n_ack, n_nack, n_ignored, stall_cycles);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- ack_reply_checker.f -----
src/acr_pkg.sv
src/acr_byte_if.sv
src/acr_result_if.sv
src/acr_front.sv
src/acr_queue.sv
src/acr_back.sv
src/ack_reply_checker.sv
test/ack_reply_checker_tb.sv
